/* rtl/csfd_pkg.sv */
`timescale 1ns / 1ps

package csfd_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 128;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_TYPE_BYTE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_LENGTH    = 2'd2;

    localparam logic [7:0] START_BYTE_RESET       = 8'd170;
    localparam logic [7:0] CONFIG_TYPE_BYTE_RESET = 8'd85;
    localparam logic [7:0] CONFIG_LENGTH_RESET    = 8'd20;

    localparam logic [1:0] TYPE_MARK     = 2'b11;
    localparam logic [3:0] DLC_MASK      = 4'hf;
    localparam logic [3:0] MAX_DATA_LEN  = 4'd8;
    localparam logic [2:0] STD_ID_BYTES  = 3'd2;
    localparam logic [2:0] EXT_ID_BYTES  = 3'd4;

    typedef struct packed {
        logic [28:0] frame_id;
        logic        is_extended;
        logic        is_rtr;
        logic [3:0]  length;
        logic [63:0] payload;
    } frame_t;

    function automatic logic [2:0] id_bytes(input logic [7:0] type_byte);
        return type_byte[5] ? EXT_ID_BYTES : STD_ID_BYTES;
    endfunction

endpackage

/* rtl/csfd_parser.sv */
`timescale 1ns / 1ps

module csfd_parser #(
    parameter int BUFFER_BYTES = csfd_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic [7:0]                       rx_byte,
    input  logic                             byte_error,
    input  logic                             cfg_we,
    input  logic [csfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    output logic                             res_valid,
    output csfd_pkg::frame_t                 res
);
    import csfd_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] BUF_FULL = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] POS_START = CNT_W'(0);
    localparam logic [CNT_W-1:0] POS_TYPE = CNT_W'(1);

    logic [7:0]       start_reg;
    logic [7:0]       cfg_type_reg;
    logic [7:0]       cfg_len_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [4:0]       exp_reg, exp_next;
    logic [7:0]       type_reg, type_next;
    logic [31:0]      id_reg, id_next;
    logic [63:0]      pay_reg, pay_next;
    logic             skip_reg, skip_next;

    logic [CNT_W-1:0] cnt1;
    logic [CNT_W-1:0] hdr_end;
    logic [CNT_W-1:0] data_idx;
    logic [1:0]       id_idx;
    logic [3:0]       dlc;
    logic [2:0]       idn;

    assign cnt1     = count_reg + 1'b1;
    assign dlc      = type_reg[3:0] & DLC_MASK;
    assign idn      = id_bytes(type_reg);
    assign hdr_end  = CNT_W'(2) + CNT_W'(idn);
    assign data_idx = count_reg - hdr_end;
    assign id_idx   = 2'(count_reg - CNT_W'(2));

    always_comb
    begin
        count_next = count_reg;
        exp_next   = exp_reg;
        type_next  = type_reg;
        id_next    = id_reg;
        pay_next   = pay_reg;
        skip_next  = skip_reg;
        res_valid  = 1'b0;
        if (step)
        begin
            if (byte_error)
            begin
                skip_next = 1'b1;
            end
            else if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else if (count_reg >= BUF_FULL)
            begin
                count_next = '0;
                exp_next   = '0;
            end
            else if (count_reg == POS_START)
            begin
                count_next = (rx_byte == start_reg) ? cnt1 : '0;
            end
            else if (count_reg == POS_TYPE)
            begin
                type_next  = rx_byte;
                id_next    = '0;
                pay_next   = '0;
                exp_next   = '0;
                count_next = cnt1;
                if (rx_byte == cfg_type_reg)
                begin
                    if (CMP_W'(cnt1) >= CMP_W'(cfg_len_reg))
                    begin
                        count_next = '0;
                    end
                end
                else if (rx_byte[7:6] == TYPE_MARK)
                begin
                    exp_next = 5'(3) + 5'(id_bytes(rx_byte)) + 5'(rx_byte[3:0] & DLC_MASK);
                end
                else
                begin
                    count_next = '0;
                end
            end
            else if (exp_reg == '0)
            begin
                count_next = (CMP_W'(cnt1) >= CMP_W'(cfg_len_reg)) ? '0 : cnt1;
            end
            else
            begin
                if (count_reg < hdr_end)
                begin
                    id_next[8*id_idx +: 8] = rx_byte;
                end
                else if ((CMP_W'(data_idx) < CMP_W'(dlc)) &&
                         (CMP_W'(data_idx) < CMP_W'(MAX_DATA_LEN)))
                begin
                    pay_next[8*data_idx[2:0] +: 8] = rx_byte;
                end
                if (CMP_W'(cnt1) >= CMP_W'(exp_reg))
                begin
                    res_valid  = 1'b1;
                    count_next = '0;
                    exp_next   = '0;
                end
                else
                begin
                    count_next = cnt1;
                end
            end
        end
    end

    always_comb
    begin
        res.is_extended = type_reg[5];
        res.is_rtr      = type_reg[4];
        res.frame_id    = type_reg[5] ? id_reg[28:0] : {18'd0, id_reg[10:0]};
        res.length      = (dlc > MAX_DATA_LEN) ? MAX_DATA_LEN : dlc;
        res.payload     = type_reg[4] ? 64'd0 : pay_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            exp_reg   <= '0;
            type_reg  <= '0;
            id_reg    <= '0;
            pay_reg   <= '0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            exp_reg   <= exp_next;
            type_reg  <= type_next;
            id_reg    <= id_next;
            pay_reg   <= pay_next;
            skip_reg  <= skip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= START_BYTE_RESET;
            cfg_type_reg <= CONFIG_TYPE_BYTE_RESET;
            cfg_len_reg  <= CONFIG_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE:       start_reg    <= cfg_data;
                CFG_CONFIG_TYPE_BYTE: cfg_type_reg <= cfg_data;
                CFG_CONFIG_LENGTH:    cfg_len_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

endmodule

/* rtl/can_serial_frame_deframer.sv */
`timescale 1ns / 1ps

// Serial CAN packet deframer. Bytes enter on the input channel (in_valid, in_ready,
// rx_byte, byte_error), one transaction per byte. Decoded frames leave on the output
// channel (out_valid, out_ready, frame_id, is_extended, is_rtr, length, payload),
// one transaction per completed data packet.
// A byte is taken in every cycle while in_ready is high. The frame is held in the
// output register from the cycle after the closing byte is accepted when that
// register is empty or drained; otherwise it waits in the second result register.
// A second result register behind the output register lets parsing continue while
// a finished frame waits; in_ready drops only when both registers hold frames,
// and rises again once the receiver takes a frame.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the start byte, the
// configuration type byte or the configuration packet length, as chosen by cfg_index.
// Reset loads the default register values, clears the parser and empties both
// result registers.
module can_serial_frame_deframer #(
    parameter int BUFFER_BYTES = csfd_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    input  logic                             byte_error,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [28:0]                      frame_id,
    output logic                             is_extended,
    output logic                             is_rtr,
    output logic [3:0]                       length,
    output logic [63:0]                      payload,
    input  logic                             cfg_we,
    input  logic [csfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);
    import csfd_pkg::*;

    logic   step;
    logic   res_valid;
    frame_t res;

    frame_t out_reg;
    logic   out_valid_reg;
    frame_t skid_reg;
    logic   skid_valid_reg;
    logic   drain;

    assign in_ready = !skid_valid_reg;
    assign step     = in_valid && in_ready;
    assign drain    = out_valid_reg && out_ready;

    csfd_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (rx_byte),
        .byte_error(byte_error),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || drain)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (!out_valid_reg || drain)
        begin
            if (res_valid)
            begin
                out_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_id    = out_reg.frame_id;
    assign is_extended = out_reg.is_extended;
    assign is_rtr      = out_reg.is_rtr;
    assign length      = out_reg.length;
    assign payload     = out_reg.payload;

endmodule
